// ----- rtl/core/byte_wide_bridge_bus_master_defines.svh -----
// Assertion macros for the bridge bus master. Both expect clk and rst_n in scope.
`ifndef BYTE_WIDE_BRIDGE_BUS_MASTER_DEFINES_SVH
`define BYTE_WIDE_BRIDGE_BUS_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
`define BWBM_ASSERT_NOW(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bwbm assertion failed");
`define BWBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bwbm assertion failed");
`else
`define BWBM_ASSERT_NOW(lbl, prop)
`define BWBM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/bwbm_pkg.sv -----
`default_nettype none

package bwbm_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;
  localparam logic [1:0] REQ_END    = 2'd3;

  localparam logic [2:0] KIND_ADDR  = 3'd0;
  localparam logic [2:0] KIND_WBYTE = 3'd1;
  localparam logic [2:0] KIND_RCLK  = 3'd2;
  localparam logic [2:0] KIND_FIN   = 3'd3;
  localparam logic [2:0] KIND_WORD  = 3'd4;

  // Beat slots of one request: finish, five address bytes, up to four body beats
  localparam int NUM_POS = 10;
  localparam logic [3:0] POS_FIN      = 4'd0;
  localparam logic [3:0] POS_ADDR0    = 4'd1;
  localparam logic [3:0] POS_ADDR1    = 4'd2;
  localparam logic [3:0] POS_ADDR2    = 4'd3;
  localparam logic [3:0] POS_ADDR3    = 4'd4;
  localparam logic [3:0] POS_ADDR_TOP = 4'd5;
  localparam logic [3:0] POS_BODY0    = 4'd6;

  localparam logic [1:0] BODY_IDX_FIRST = 2'd0;
  localparam logic [1:0] BODY_IDX_LAST  = 2'd3;

  typedef enum logic [1:0] {
    BODY_NONE   = 2'd0,
    BODY_WBYTES = 2'd1,
    BODY_RCLKS  = 2'd2,
    BODY_WORD   = 2'd3
  } body_t;

  typedef struct packed {
    logic [NUM_POS-1:0] mask;
    body_t              body;
    logic [31:0]        data;
  } plan_t;

  typedef struct packed {
    logic [2:0]  beat_kind;
    logic [7:0]  bus_byte;
    logic        start_strobe;
    logic        wait_before;
    logic        wait_after;
    logic [31:0] read_word;
    logic        last_beat;
  } beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/bwbm_in_if.sv -----
`default_nettype none

interface bwbm_in_if #(parameter int ADDR_BITS = 36);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ADDR_BITS-1:0] word_address;
  logic [31:0]          write_word;
  logic                 burst_first;
  logic [7:0]           sampled_byte;

  modport source (output valid, req_type, word_address, write_word, burst_first,
                  sampled_byte, input ready);
  modport sink (input valid, req_type, word_address, write_word, burst_first,
                sampled_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bwbm_out_if.sv -----
`default_nettype none

interface bwbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  beat_kind;
  logic [7:0]  bus_byte;
  logic        start_strobe;
  logic        wait_before;
  logic        wait_after;
  logic [31:0] read_word;
  logic        last_beat;

  modport source (output valid, beat_kind, bus_byte, start_strobe, wait_before,
                  wait_after, read_word, last_beat, input ready);
  modport sink (input valid, beat_kind, bus_byte, start_strobe, wait_before,
                wait_after, read_word, last_beat, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bwbm_plan.sv -----
`default_nettype none

// Decodes a request into its beat plan and keeps the read state.
module bwbm_plan #(
  parameter int ADDR_BITS    = 36,
  parameter int AUTOINC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [1:0]           req_type,
  input  wire logic [ADDR_BITS-1:0] word_address,
  input  wire logic [31:0]          write_word,
  input  wire logic                 burst_first,
  input  wire logic [7:0]           sampled_byte,
  output bwbm_pkg::plan_t           plan,
  output logic                      read_open
);

  logic        read_open_r, read_open_nxt;
  logic [1:0]  sample_count_r, sample_count_nxt;
  logic [23:0] partial_word_r, partial_word_nxt;
  logic        resend;
  logic        fin_en;
  logic        addr_en;

  assign resend = burst_first || (word_address[AUTOINC_BITS-1:0] == '0);

  always_comb begin
    read_open_nxt    = read_open_r;
    sample_count_nxt = sample_count_r;
    partial_word_nxt = partial_word_r;
    fin_en           = 1'b0;
    addr_en          = 1'b0;
    plan.body        = bwbm_pkg::BODY_NONE;
    plan.data        = write_word;
    unique case (req_type)
      bwbm_pkg::REQ_WRITE: begin
        fin_en           = read_open_r;
        addr_en          = resend;
        plan.body        = bwbm_pkg::BODY_WBYTES;
        read_open_nxt    = 1'b0;
        sample_count_nxt = '0;
        partial_word_nxt = '0;
      end
      bwbm_pkg::REQ_READ: begin
        // an open read is closed only when the address goes out again
        fin_en           = resend && read_open_r;
        addr_en          = resend;
        plan.body        = bwbm_pkg::BODY_RCLKS;
        read_open_nxt    = 1'b1;
        sample_count_nxt = '0;
        partial_word_nxt = '0;
      end
      bwbm_pkg::REQ_SAMPLE: begin
        if (read_open_r) begin
          if (sample_count_r == 2'd3) begin
            plan.body        = bwbm_pkg::BODY_WORD;
            plan.data        = {sampled_byte, partial_word_r};
            sample_count_nxt = '0;
            partial_word_nxt = '0;
          end else begin
            sample_count_nxt = sample_count_r + 2'd1;
            case (sample_count_r)
              2'd0:    partial_word_nxt[7:0]   = partial_word_r[7:0] | sampled_byte;
              2'd1:    partial_word_nxt[15:8]  = partial_word_r[15:8] | sampled_byte;
              default: partial_word_nxt[23:16] = partial_word_r[23:16] | sampled_byte;
            endcase
          end
        end
      end
      bwbm_pkg::REQ_END: begin
        fin_en           = 1'b1;
        read_open_nxt    = 1'b0;
        sample_count_nxt = '0;
        partial_word_nxt = '0;
      end
      default: ;
    endcase

    plan.mask    = '0;
    plan.mask[0] = fin_en;
    plan.mask[5:1] = {5{addr_en}};
    case (plan.body)
      bwbm_pkg::BODY_WBYTES, bwbm_pkg::BODY_RCLKS: plan.mask[9:6] = 4'b1111;
      bwbm_pkg::BODY_WORD:                          plan.mask[9:6] = 4'b0001;
      default:                                      plan.mask[9:6] = 4'b0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_open_r    <= 1'b0;
      sample_count_r <= '0;
      partial_word_r <= '0;
    end else if (accept) begin
      read_open_r    <= read_open_nxt;
      sample_count_r <= sample_count_nxt;
      partial_word_r <= partial_word_nxt;
    end
  end

  assign read_open = read_open_r;

endmodule

`default_nettype wire

// ----- rtl/core/bwbm_seq.sv -----
`default_nettype none

// Holds a request's plan; issues its beats into the output register, one per cycle when not stalled.
module bwbm_seq #(
  parameter int ADDR_BITS = 36
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire bwbm_pkg::plan_t      plan,
  input  wire logic [ADDR_BITS-1:0] word_address,
  output logic                      in_ready,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output bwbm_pkg::beat_t           beat
);

  logic [bwbm_pkg::NUM_POS-1:0] mask_r;
  bwbm_pkg::body_t              body_r;
  logic [31:0]                  data_r;
  logic [ADDR_BITS-1:0]         addr_r;
  logic                         out_valid_r;
  bwbm_pkg::beat_t              beat_r, beat_nxt;
  logic                         busy;
  logic                         adv;
  logic                         last;
  logic [3:0]                   pos;
  logic [1:0]                   body_idx;

  assign busy     = |mask_r;
  assign adv      = busy && (!out_valid_r || out_ready);
  assign last     = (mask_r & (mask_r - 1'b1)) == '0;
  assign in_ready = !busy || (adv && last);

  // lowest pending slot
  always_comb begin
    pos = '0;
    for (int i = bwbm_pkg::NUM_POS - 1; i >= 0; i--) begin
      if (mask_r[i]) pos = 4'(i);
    end
  end

  assign body_idx = 2'(pos - bwbm_pkg::POS_BODY0);

  always_comb begin
    beat_nxt           = '0;
    beat_nxt.last_beat = last;
    if (pos == bwbm_pkg::POS_FIN) begin
      beat_nxt.beat_kind  = bwbm_pkg::KIND_FIN;
      beat_nxt.wait_after = 1'b1;
    end else if (pos <= bwbm_pkg::POS_ADDR_TOP) begin
      beat_nxt.beat_kind    = bwbm_pkg::KIND_ADDR;
      beat_nxt.start_strobe = (pos == bwbm_pkg::POS_ADDR0);
      beat_nxt.wait_before  = (pos == bwbm_pkg::POS_ADDR0);
      case (pos)
        bwbm_pkg::POS_ADDR0: beat_nxt.bus_byte = addr_r[7:0];
        bwbm_pkg::POS_ADDR1: beat_nxt.bus_byte = addr_r[15:8];
        bwbm_pkg::POS_ADDR2: beat_nxt.bus_byte = addr_r[23:16];
        bwbm_pkg::POS_ADDR3: beat_nxt.bus_byte = addr_r[31:24];
        default:             beat_nxt.bus_byte = 8'(addr_r >> 32);
      endcase
    end else begin
      case (body_r)
        bwbm_pkg::BODY_WBYTES: begin
          beat_nxt.beat_kind  = bwbm_pkg::KIND_WBYTE;
          beat_nxt.bus_byte   = 8'(data_r >> {body_idx, 3'b000});
          beat_nxt.wait_after = (body_idx == bwbm_pkg::BODY_IDX_LAST);
        end
        bwbm_pkg::BODY_RCLKS: begin
          beat_nxt.beat_kind  = bwbm_pkg::KIND_RCLK;
          beat_nxt.wait_after = (body_idx == bwbm_pkg::BODY_IDX_FIRST);
        end
        bwbm_pkg::BODY_WORD: begin
          beat_nxt.beat_kind = bwbm_pkg::KIND_WORD;
          beat_nxt.read_word = data_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mask_r <= plan.mask;
      end else if (adv) begin
        mask_r <= mask_r & (mask_r - 1'b1);
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      body_r <= plan.body;
      data_r <= plan.data;
      addr_r <= word_address;
    end
    if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign beat      = beat_r;

endmodule

`default_nettype wire

// ----- rtl/core/byte_wide_bridge_bus_master.sv -----
// A request's plan is registered in the sequencer; its beats then pass through the output register.
// Throughput: one beat per cycle unless the output stalls; a request has 0 to 10 beats,
// issued by the single beat sequencer; the next request is taken in the cycle its last beat issues.
// Requests with no beats (stray or partial read bytes) leave the sequencer idle and ready.
// Reset (synchronous, rst_n low) closes the read, clears the partial word and empties the output.
`default_nettype none

`include "byte_wide_bridge_bus_master_defines.svh"

module byte_wide_bridge_bus_master #(
  parameter int ADDR_BITS    = 36,
  parameter int AUTOINC_BITS = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  bwbm_in_if.sink    in_ch,
  bwbm_out_if.source out_ch
);

  logic            accept;
  logic            in_ready;
  logic            out_valid;
  logic            read_open;
  logic            out_fire;
  logic            addr_plain;
  logic            read_accept;
  bwbm_pkg::plan_t plan;
  bwbm_pkg::beat_t beat;

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  bwbm_plan #(
    .ADDR_BITS    (ADDR_BITS),
    .AUTOINC_BITS (AUTOINC_BITS)
  ) u_plan (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_ch.req_type),
    .word_address (in_ch.word_address),
    .write_word   (in_ch.write_word),
    .burst_first  (in_ch.burst_first),
    .sampled_byte (in_ch.sampled_byte),
    .plan         (plan),
    .read_open    (read_open)
  );

  bwbm_seq #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .plan         (plan),
    .word_address (in_ch.word_address),
    .in_ready     (in_ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_valid),
    .beat         (beat)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.beat_kind    = beat.beat_kind;
  assign out_ch.bus_byte     = beat.bus_byte;
  assign out_ch.start_strobe = beat.start_strobe;
  assign out_ch.wait_before  = beat.wait_before;
  assign out_ch.wait_after   = beat.wait_after;
  assign out_ch.read_word    = beat.read_word;
  assign out_ch.last_beat    = beat.last_beat;

  assign out_fire    = out_valid && out_ch.ready;
  assign addr_plain  = out_valid && (beat.beat_kind == bwbm_pkg::KIND_ADDR) && !beat.start_strobe;
  assign read_accept = accept && (in_ch.req_type == bwbm_pkg::REQ_READ);

  // the strobed address byte is always followed at once by a plain address byte
  `BWBM_ASSERT_NEXT(a_addr_follows, out_fire && beat.start_strobe, addr_plain)
  `BWBM_ASSERT_NOW(a_wait_before_strobe, !out_valid || (beat.wait_before == beat.start_strobe))
  // a read opens only through an accepted read request
  `BWBM_ASSERT_NOW(a_read_open_src, !$rose(read_open) || $past(read_accept))

endmodule

`default_nettype wire
